[src/abfl_pkg.sv]
// ----------------------------------------------------------------------------
// abfl_pkg
// shared constants for the ipv4 address blocklist filter
// ----------------------------------------------------------------------------
package abfl_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int ADDR_W            = 32;
    localparam int COUNT_W           = 32;
    localparam int WORD_W            = ADDR_W + COUNT_W;

    localparam logic [15:0] MIN_FRAME_BYTES = 16'd42;

    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    localparam logic TAB_DST = 1'b0;
    localparam logic TAB_SRC = 1'b1;

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

endpackage

[src/abfl_ram.sv]
// ----------------------------------------------------------------------------
// abfl_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module abfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ipv4_address_blocklist_filter.sv]
// ----------------------------------------------------------------------------
// ipv4_address_blocklist_filter
// packet filter with destination and source exact-match address tables
// ----------------------------------------------------------------------------
// Each table is a ram of {counter, address} words kept packed at the low end:
// a fill count marks the live entries, insert appends, remove moves the last
// entry into the hole, so no clearing pass is needed after reset. One beat is
// taken at a time. A lookup scans the live entries through the ram read port,
// one entry a cycle; a packet scans the destination table and then, on a miss,
// the source table, and a frame shorter than 42 bytes skips the scan. The
// result sits in an output register while the next beat is accepted.
module ipv4_address_blocklist_filter
    import abfl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_length, source_address, destination_address, key_address
    input  logic [111:0] s_axis_tdata,
    // action, table_select
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict, report_destination, report_source, status, count_value, pad
    output logic [103:0] m_axis_tdata,
    // matched_list, report_valid
    output logic [1:0]   m_axis_tuser
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_REM_RD, S_REM_WR, S_DONE} t_state;

    t_state          r_state;
    t_action         r_act;
    logic            r_tab;
    logic [31:0]     r_key, r_src, r_dst;
    logic [CW-1:0]   r_cnt [2];
    logic [CW-1:0]   r_addr;
    logic [AW-1:0]   r_paddr, r_hit;
    logic            r_pend;

    logic            r_verdict, r_matched, r_rvalid;
    t_status         r_status;
    logic [31:0]     r_cval;

    logic            r_mv;
    logic [103:0]    r_mdata;
    logic [1:0]      r_muser;

    logic [WORD_W-1:0] w_rdata [2];
    logic [WORD_W-1:0] w_word, w_wdata;
    logic [AW-1:0]     w_raddr, w_waddr;
    logic              w_we;
    logic [CW-1:0]     w_cnt;
    logic              w_hit, w_end;

    assign w_word = w_rdata[r_tab];
    assign w_cnt  = r_cnt[r_tab];
    assign w_hit  = r_pend && (w_word[ADDR_W-1:0] == r_key);
    assign w_end  = !w_hit && (r_addr >= w_cnt);

    always_comb begin
        w_raddr = r_addr[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_paddr;
        w_wdata = {{COUNT_W{1'b0}}, r_key};
        if (r_state == S_REM_RD) begin
            w_raddr = AW'(w_cnt - 1'b1);
        end
        case (r_state)
            S_SCAN: begin
                if (w_hit) begin
                    if (r_act == ACT_PACKET) begin
                        w_we    = 1'b1;
                        w_wdata = {w_word[WORD_W-1:ADDR_W] + 1'b1, r_key};
                    end else if (r_act == ACT_INSERT) begin
                        w_we = 1'b1;
                    end
                end else if (w_end && r_act == ACT_INSERT && w_cnt != FULL_CNT) begin
                    w_we    = 1'b1;
                    w_waddr = w_cnt[AW-1:0];
                end
            end
            S_REM_WR: begin
                w_we    = 1'b1;
                w_waddr = r_hit;
                w_wdata = w_word;
            end
            default: ;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < 2; g++) begin : g_tab
            abfl_ram #(
                .WIDTH (WORD_W),
                .DEPTH (TABLE_ENTRIES),
                .AW    (AW)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we && (r_tab == 1'(g))),
                .i_waddr (w_waddr),
                .i_wdata (w_wdata),
                .i_raddr (w_raddr),
                .o_rdata (w_rdata[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_pend   <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_DONE) begin
                r_mv <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_act     <= t_action'(s_axis_tuser[1:0]);
                        r_src     <= s_axis_tdata[47:16];
                        r_dst     <= s_axis_tdata[79:48];
                        r_addr    <= '0;
                        r_pend    <= 1'b0;
                        r_verdict <= VERDICT_PASS;
                        r_matched <= 1'b0;
                        r_rvalid  <= 1'b0;
                        r_status  <= ST_OK;
                        r_cval    <= '0;
                        if (t_action'(s_axis_tuser[1:0]) == ACT_PACKET) begin
                            r_tab <= TAB_DST;
                            r_key <= s_axis_tdata[79:48];
                            r_state <= (s_axis_tdata[15:0] < MIN_FRAME_BYTES) ? S_DONE
                                                                               : S_SCAN;
                        end else begin
                            r_tab   <= s_axis_tuser[2];
                            r_key   <= s_axis_tdata[111:80];
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_pend <= 1'b0;
                        case (r_act)
                            ACT_PACKET: begin
                                r_verdict <= VERDICT_DROP;
                                r_matched <= r_tab;
                                r_rvalid  <= 1'b1;
                                r_state   <= S_DONE;
                            end
                            ACT_REMOVE: begin
                                r_hit   <= r_paddr;
                                r_state <= S_REM_RD;
                            end
                            ACT_READ: begin
                                r_cval  <= w_word[WORD_W-1:ADDR_W];
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end else if (w_end) begin
                        r_pend <= 1'b0;
                        case (r_act)
                            ACT_PACKET: begin
                                if (r_tab == TAB_DST) begin
                                    r_tab  <= TAB_SRC;
                                    r_key  <= r_src;
                                    r_addr <= '0;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            ACT_INSERT: begin
                                if (w_cnt == FULL_CNT) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_cnt[r_tab] <= w_cnt + 1'b1;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_paddr <= r_addr[AW-1:0];
                        r_pend  <= 1'b1;
                        r_addr  <= r_addr + 1'b1;
                    end
                end
                S_REM_RD: r_state <= S_REM_WR;
                S_REM_WR: begin
                    r_cnt[r_tab] <= w_cnt - 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (!r_mv || m_axis_tready) begin
                        r_mv    <= 1'b1;
                        r_mdata <= {5'd0, r_cval, r_status, r_src & {32{r_rvalid}},
                                    r_dst & {32{r_rvalid}}, r_verdict};
                        r_muser <= {r_rvalid, r_matched};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= FULL_CNT && r_cnt[1] <= FULL_CNT)
        else $error("fill count beyond table size");

    a_drop_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tuser[1]))
        else $error("drop verdict without report");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM_WR) |=> (r_cnt[r_tab] == $past(w_cnt) - 1'b1))
        else $error("remove did not shrink table");

endmodule
